// ----- rtl/tiled_texture_decoder_macros.svh -----
// assertion macros for the tiled texture decoder checker
`ifndef TILED_TEXTURE_DECODER_MACROS_SVH
`define TILED_TEXTURE_DECODER_MACROS_SVH

// same-cycle implication, checked outside reset
`define TTD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tiled texture decoder check failed");

// next-cycle implication, checked outside reset
`define TTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tiled texture decoder check failed");

`endif

// ----- rtl/ttd_pkg.sv -----
// shared types, constants and colour helpers of the tiled texture decoder
package ttd_pkg;

    localparam int PAL_DEPTH = 16384;
    localparam int PAL_AW    = 14;
    localparam int LANES     = 16;
    localparam logic [10:0] MAX_DIM = 11'd1024;

    // texture format codes
    localparam logic [3:0] FMT_I4     = 4'd0;
    localparam logic [3:0] FMT_I8     = 4'd1;
    localparam logic [3:0] FMT_IA4    = 4'd2;
    localparam logic [3:0] FMT_IA8    = 4'd3;
    localparam logic [3:0] FMT_RGB565 = 4'd4;
    localparam logic [3:0] FMT_RGB5A3 = 4'd5;
    localparam logic [3:0] FMT_RGBA8  = 4'd6;
    localparam logic [3:0] FMT_C4     = 4'd8;
    localparam logic [3:0] FMT_C8     = 4'd9;
    localparam logic [3:0] FMT_C14X2  = 4'd10;
    localparam logic [3:0] FMT_CMPR   = 4'd14;

    // palette entry formats
    localparam logic [1:0] PF_IA8    = 2'd0;
    localparam logic [1:0] PF_RGB565 = 2'd1;

    // register indexes
    localparam logic [1:0] REG_FORMAT  = 2'd0;
    localparam logic [1:0] REG_PALFMT  = 2'd1;
    localparam logic [1:0] REG_WIDTH   = 2'd2;
    localparam logic [1:0] REG_HEIGHT  = 2'd3;

    typedef struct packed {
        logic              valid;
        logic              pal;
        logic [PAL_AW-1:0] pidx;
        logic [9:0]        x;
        logic [9:0]        y;
        logic [31:0]       rgba;   // r in the top byte, a in the lowest
    } texel_t;

    typedef struct packed {
        logic [3:0]       fmt;
        logic [2:0]       k;
        logic [9:0]       x0;
        logic [9:0]       y0;
        logic [10:0]      wc;
        logic [10:0]      hc;
        logic [63:0]      word;
        logic [63:0]      ar;
        logic [3:0][31:0] cpal;
    } lane_ctl_t;

    function automatic logic [7:0] byte_of(input logic [63:0] w, input logic [2:0] n);
        return w[8*(7-n) +: 8];
    endfunction

    function automatic logic [15:0] half_of(input logic [63:0] w, input logic [1:0] n);
        return w[16*(3-n) +: 16];
    endfunction

    // 3-bit alpha scaled to 0..255
    function automatic logic [7:0] alpha3(input logic [2:0] v);
        logic [7:0] a;
        case (v)
            3'd0:    a = 8'd0;
            3'd1:    a = 8'd36;
            3'd2:    a = 8'd72;
            3'd3:    a = 8'd109;
            3'd4:    a = 8'd145;
            3'd5:    a = 8'd182;
            3'd6:    a = 8'd218;
            default: a = 8'd255;
        endcase
        return a;
    endfunction

    function automatic logic [31:0] from_565(input logic [15:0] v);
        return {v[15:11], v[15:13], v[10:5], v[10:9], v[4:0], v[4:2], 8'hFF};
    endfunction

    function automatic logic [31:0] from_5a3(input logic [15:0] v);
        logic [31:0] c;
        if (v[15])
            c = {v[14:10], v[14:12], v[9:5], v[9:7], v[4:0], v[4:2], 8'hFF};
        else
            c = {v[11:8], v[11:8], v[7:4], v[7:4], v[3:0], v[3:0], alpha3(v[14:12])};
        return c;
    endfunction

    function automatic logic [31:0] from_ia8(input logic [15:0] v);
        return {v[7:0], v[7:0], v[7:0], v[15:8]};
    endfunction

    function automatic logic [31:0] from_palette(input logic [1:0] pf, input logic [15:0] v);
        logic [31:0] c;
        if (pf == PF_IA8)
            c = from_ia8(v);
        else if (pf == PF_RGB565)
            c = from_565(v);
        else
            c = from_5a3(v);
        return c;
    endfunction

    // floor(v / 3) for v up to 765, by reciprocal
    function automatic logic [7:0] div3(input logic [9:0] v);
        logic [19:0] p;
        p = v * 10'd683;
        return p[18:11];
    endfunction

endpackage

// ----- rtl/ttd_ram.sv -----
// generic single-write, single-read ram with registered read
module ttd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ttd_lane.sv -----
// one decode lane: position, clipping and colour of one texel of a word
module ttd_lane (
    input  ttd_pkg::lane_ctl_t ctl,
    input  logic [3:0]         lane_id,
    output ttd_pkg::texel_t    tex
);
    import ttd_pkg::*;

    logic [7:0]  bv;
    logic [3:0]  nib;
    logic [15:0] hv;
    logic [2:0]  xo;
    logic [2:0]  yo;
    logic [1:0]  ci;
    logic        live;
    logic [10:0] xx;
    logic [10:0] yy;

    always_comb
    begin
        tex  = '0;
        live = 1'b0;
        xo   = '0;
        yo   = '0;
        bv   = '0;
        nib  = '0;
        hv   = '0;
        ci   = '0;
        case (ctl.fmt)
            FMT_I4, FMT_C4:
            begin
                live = 1'b1;
                bv   = byte_of(ctl.word, lane_id[3:1]);
                nib  = lane_id[0] ? bv[3:0] : bv[7:4];
                xo   = lane_id[2:0];
                yo   = {ctl.k[1:0], lane_id[3]};
                if (ctl.fmt == FMT_I4)
                    tex.rgba = {4{nib, nib}};
                else
                begin
                    tex.pal  = 1'b1;
                    tex.pidx = PAL_AW'(nib);
                end
            end
            FMT_I8, FMT_IA4, FMT_C8:
            begin
                live = !lane_id[3];
                bv   = byte_of(ctl.word, lane_id[2:0]);
                xo   = lane_id[2:0];
                yo   = {1'b0, ctl.k[1:0]};
                if (ctl.fmt == FMT_I8)
                    tex.rgba = {4{bv}};
                else if (ctl.fmt == FMT_IA4)
                    tex.rgba = {{3{bv[3:0], bv[3:0]}}, bv[7:4], bv[7:4]};
                else
                begin
                    tex.pal  = 1'b1;
                    tex.pidx = PAL_AW'(bv);
                end
            end
            FMT_IA8, FMT_RGB565, FMT_RGB5A3, FMT_C14X2:
            begin
                live = (lane_id[3:2] == 2'b00);
                hv   = half_of(ctl.word, lane_id[1:0]);
                xo   = {1'b0, lane_id[1:0]};
                yo   = {1'b0, ctl.k[1:0]};
                if (ctl.fmt == FMT_IA8)
                    tex.rgba = from_ia8(hv);
                else if (ctl.fmt == FMT_RGB565)
                    tex.rgba = from_565(hv);
                else if (ctl.fmt == FMT_RGB5A3)
                    tex.rgba = from_5a3(hv);
                else
                begin
                    tex.pal  = 1'b1;
                    tex.pidx = hv[PAL_AW-1:0];
                end
            end
            FMT_RGBA8:
            begin
                // gb plane word: ar comes from the buffered plane
                live = ctl.k[2] && (lane_id[3:2] == 2'b00);
                xo   = {1'b0, lane_id[1:0]};
                yo   = {1'b0, ctl.k[1:0]};
                tex.rgba = {byte_of(ctl.ar,   {lane_id[1:0], 1'b1}),
                            byte_of(ctl.word, {lane_id[1:0], 1'b0}),
                            byte_of(ctl.word, {lane_id[1:0], 1'b1}),
                            byte_of(ctl.ar,   {lane_id[1:0], 1'b0})};
            end
            FMT_CMPR:
            begin
                live = 1'b1;
                bv   = byte_of(ctl.word, {1'b1, lane_id[3:2]});
                ci   = 2'(bv >> {~lane_id[1:0], 1'b0});
                xo   = {ctl.k[0], lane_id[1:0]};
                yo   = {ctl.k[1], lane_id[3:2]};
                tex.rgba = ctl.cpal[ci];
            end
            default:
            begin
                live = 1'b0;
            end
        endcase
        xx = {1'b0, ctl.x0} + {8'b0, xo};
        yy = {1'b0, ctl.y0} + {8'b0, yo};
        tex.x     = xx[9:0];
        tex.y     = yy[9:0];
        tex.valid = live && (xx < ctl.wc) && (yy < ctl.hc);
    end

endmodule

// ----- rtl/ttd_cmpr.sv -----
// four-entry colour table of one dxt1 sub-block
module ttd_cmpr (
    input  logic [63:0]      word,
    output logic [3:0][31:0] cpal
);
    import ttd_pkg::*;

    logic [15:0] c0;
    logic [15:0] c1;
    logic [31:0] p0;
    logic [31:0] p1;
    logic        four;
    logic [8:0]  sum1;
    logic [9:0]  two_a;
    logic [9:0]  two_b;

    always_comb
    begin
        c0   = word[63:48];
        c1   = word[47:32];
        p0   = from_565(c0);
        p1   = from_565(c1);
        four = c0 > c1;
        cpal[0] = p0;
        cpal[1] = p1;
        cpal[2] = '0;
        cpal[3] = '0;
        sum1  = '0;
        two_a = '0;
        two_b = '0;
        for (int m = 0; m < 3; m++)
        begin
            sum1  = {1'b0, p0[31-8*m -: 8]} + {1'b0, p1[31-8*m -: 8]};
            two_a = {1'b0, sum1} + {2'b0, p0[31-8*m -: 8]};
            two_b = {1'b0, sum1} + {2'b0, p1[31-8*m -: 8]};
            if (four)
            begin
                cpal[2][31-8*m -: 8] = div3(two_a);
                cpal[3][31-8*m -: 8] = div3(two_b);
            end
            else
            begin
                cpal[2][31-8*m -: 8] = sum1[8:1];
                cpal[3][31-8*m -: 8] = 8'd0;
            end
        end
        cpal[2][7:0] = 8'hFF;
        cpal[3][7:0] = four ? 8'hFF : 8'h00;
    end

endmodule

// ----- rtl/tiled_texture_decoder.sv -----
// top level of the tiled texture decoder
// Takes tiled texture data as 64-bit big-endian words and returns RGBA8 texels
// with their image coordinates, one texel per output word. Sixteen decode lanes
// turn a whole input word combinationally into up to sixteen texels; these wait
// in a lane buffer and leave one per cycle while the receiver is ready, lowest
// lane first, into the output register alongside the palette read, tlast on the
// last texel of the word. A word yields as many texels as it has visible ones
// (at most 16); words with no visible texel (palette writes, RGBA8 AR plane,
// clipped or unsupported-format words) yield none. The next word is taken in
// the cycle its predecessor's last texel moves to the output register, so
// output throughput is one texel per cycle while the receiver is ready.
// Palette formats read the 16384 x 16 palette store once per texel; entries
// hold garbage until written and need no clearing after reset. Register writes
// reset the tile position and must only happen while the block is idle.
module tiled_texture_decoder (
    input  logic        clk,
    input  logic        rst_n,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // tile_word, palette_index, palette_value, zero pad
    input  logic        s_tuser,   // func
    // texel words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // texel_x, texel_y, red, green, blue, alpha, zero pad
    output logic        m_tlast
);
    import ttd_pkg::*;

    // config registers
    logic [3:0]  fmt_reg;
    logic [1:0]  pf_reg;
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic        cfg_wr;

    // tile position
    logic [7:0]  col_reg, col_next;
    logic [7:0]  row_reg, row_next;
    logic [2:0]  k_reg, k_next;

    // ar plane buffer for rgba8
    logic [63:0] plane_reg [4];

    // lane buffer
    logic [LANES-1:0] mask_reg, mask_next;
    texel_t           lanes_reg [LANES];
    texel_t           lane_out [LANES];

    // output stage
    logic   ovalid_reg, ovalid_next;
    logic   olast_reg;
    texel_t otex_reg;

    logic [63:0]       in_word;
    logic [PAL_AW-1:0] in_pidx;
    logic [15:0]       in_pval;
    logic              in_acc;
    logic              tile_acc;
    logic              pal_we;

    logic [10:0] wc;
    logic [10:0] hc;
    logic        tw8;
    logic        th8;
    logic        supported;
    logic [3:0]  words;
    logic [2:0]  k_eff;
    logic [3:0]  k_inc;
    logic [8:0]  cols;
    logic [8:0]  rows;
    lane_ctl_t   ctl;
    logic [3:0][31:0] cpal;

    logic             adv;
    logic             any;
    logic [3:0]       pick;
    logic [LANES-1:0] pick_oh;
    logic [LANES-1:0] remain;
    logic [15:0]      pal_rdata;
    logic [31:0]      ocolor;

    assign in_word = s_tdata[63:0];
    assign in_pidx = s_tdata[77:64];
    assign in_pval = s_tdata[93:78];

    // config port: always ready, write on access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_FORMAT: prdata = {28'b0, fmt_reg};
            REG_PALFMT: prdata = {30'b0, pf_reg};
            REG_WIDTH:  prdata = {21'b0, width_reg};
            REG_HEIGHT: prdata = {21'b0, height_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= FMT_I4;
            pf_reg     <= PF_IA8;
            width_reg  <= 11'd1;
            height_reg <= 11'd1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_FORMAT: fmt_reg    <= pwdata[3:0];
                REG_PALFMT: pf_reg     <= pwdata[1:0];
                REG_WIDTH:  width_reg  <= pwdata[10:0];
                REG_HEIGHT: height_reg <= pwdata[10:0];
                default:    fmt_reg    <= fmt_reg;
            endcase
        end
    end

    // clamp sizes to 1..1024
    assign wc = (width_reg == 11'd0)  ? 11'd1 : (width_reg > MAX_DIM)  ? MAX_DIM : width_reg;
    assign hc = (height_reg == 11'd0) ? 11'd1 : (height_reg > MAX_DIM) ? MAX_DIM : height_reg;

    // tile geometry of the current format
    always_comb
    begin
        tw8       = 1'b0;
        th8       = 1'b0;
        supported = 1'b1;
        case (fmt_reg)
            FMT_I4, FMT_C4, FMT_CMPR:
            begin
                tw8 = 1'b1;
                th8 = 1'b1;
            end
            FMT_I8, FMT_IA4, FMT_C8:
            begin
                tw8 = 1'b1;
            end
            FMT_IA8, FMT_RGB565, FMT_RGB5A3, FMT_RGBA8, FMT_C14X2:
            begin
                tw8 = 1'b0;
            end
            default:
            begin
                supported = 1'b0;
            end
        endcase
    end

    assign words = (fmt_reg == FMT_RGBA8) ? 4'd8 : 4'd4;
    assign k_eff = ({1'b0, k_reg} >= words) ? 3'd0 : k_reg;
    assign k_inc = {1'b0, k_eff} + 4'd1;
    assign cols  = tw8 ? 9'(({1'b0, wc} + 12'd7) >> 3) : 9'(({1'b0, wc} + 12'd3) >> 2);
    assign rows  = th8 ? 9'(({1'b0, hc} + 12'd7) >> 3) : 9'(({1'b0, hc} + 12'd3) >> 2);

    // lane control shared by all sixteen lanes
    ttd_cmpr u_cmpr (
        .word (in_word),
        .cpal (cpal)
    );

    always_comb
    begin
        ctl.fmt  = fmt_reg;
        ctl.k    = k_eff;
        ctl.x0   = tw8 ? 10'({col_reg, 3'b0}) : 10'({col_reg, 2'b0});
        ctl.y0   = th8 ? 10'({row_reg, 3'b0}) : 10'({row_reg, 2'b0});
        ctl.wc   = wc;
        ctl.hc   = hc;
        ctl.word = in_word;
        ctl.ar   = plane_reg[k_eff[1:0]];
        ctl.cpal = cpal;
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        ttd_lane u_lane (
            .ctl     (ctl),
            .lane_id (4'(g)),
            .tex     (lane_out[g])
        );
    end

    // merge: lowest pending lane goes next
    always_comb
    begin
        pick = '0;
        for (int i = LANES - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
                pick = 4'(i);
        end
    end

    assign any     = |mask_reg;
    assign pick_oh = any ? (LANES'(1) << pick) : '0;
    assign remain  = mask_reg & ~pick_oh;
    assign adv     = !ovalid_reg || m_tready;

    // take a word once the buffer is empty or its last texel leaves now
    assign s_tready = (remain == '0) && (!any || adv);
    assign in_acc   = s_tvalid && s_tready;
    assign tile_acc = in_acc && !s_tuser && supported;
    assign pal_we   = in_acc && s_tuser;

    always_comb
    begin
        mask_next = mask_reg;
        if (adv)
            mask_next = remain;
        if (tile_acc)
        begin
            for (int i = 0; i < LANES; i++)
                mask_next[i] = lane_out[i].valid;
        end
    end

    // tile position walk
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        k_next   = k_reg;
        if (tile_acc)
        begin
            if (k_inc >= words)
            begin
                k_next = 3'd0;
                if ({1'b0, col_reg} + 9'd1 >= cols)
                begin
                    col_next = 8'd0;
                    if ({1'b0, row_reg} + 9'd1 >= rows)
                        row_next = 8'd0;
                    else
                        row_next = row_reg + 8'd1;
                end
                else
                    col_next = col_reg + 8'd1;
            end
            else
                k_next = k_inc[2:0];
        end
        if (cfg_wr)
        begin
            col_next = 8'd0;
            row_next = 8'd0;
            k_next   = 3'd0;
        end
    end

    assign ovalid_next = adv ? any : ovalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            k_reg      <= '0;
            mask_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            k_reg      <= k_next;
            mask_reg   <= mask_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (tile_acc && (fmt_reg == FMT_RGBA8) && !k_eff[2])
            plane_reg[k_eff[1:0]] <= in_word;
        if (tile_acc)
        begin
            for (int i = 0; i < LANES; i++)
                lanes_reg[i] <= lane_out[i];
        end
        if (adv && any)
        begin
            otex_reg  <= lanes_reg[pick];
            olast_reg <= (remain == '0);
        end
    end

    // palette store, read as the texel moves into the output register
    ttd_ram #(
        .WIDTH (16),
        .DEPTH (PAL_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (pal_we),
        .waddr (in_pidx),
        .wdata (in_pval),
        .re    (adv && any),
        .raddr (lanes_reg[pick].pidx),
        .rdata (pal_rdata)
    );

    assign ocolor   = otex_reg.pal ? from_palette(pf_reg, pal_rdata) : otex_reg.rgba;
    assign m_tvalid = ovalid_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {4'b0, ocolor[7:0], ocolor[15:8], ocolor[23:16], ocolor[31:24],
                       otex_reg.y, otex_reg.x};

endmodule

// ----- rtl/ttd_checker.sv -----
// port-level checks of the tiled texture decoder, bound to the top level
`include "tiled_texture_decoder_macros.svh"

module ttd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [95:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tlast
);

    // a stalled texel word holds
    `TTD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // texels of one word leave back to back
    `TTD_ASSERT_NEXT(a_burst, m_tvalid && m_tready && !m_tlast, m_tvalid)

    // config port never inserts wait states
    `TTD_ASSERT_NOW(a_pready, psel, pready)

    // no register is wider than eleven bits
    `TTD_ASSERT_NOW(a_prdata, psel, prdata[31:11] == 21'b0)

endmodule

bind tiled_texture_decoder ttd_checker u_ttd_checker (.*);

// ----- dv/ttd_checker.sv -----
// texel predictor and scoreboard for the tiled texture decoder
`timescale 1ns / 1ps

module ttd_scoreboard (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        m_tlast,
    output int          errors,
    output int          pending
);
    import ttd_pkg::*;

    typedef struct packed {
        logic [9:0] x;
        logic [9:0] y;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        logic       last;
    } exp_texel_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } color_t;

    logic [3:0]  cfg_fmt;
    logic [1:0]  cfg_pf;
    logic [10:0] cfg_w;
    logic [10:0] cfg_h;
    logic [15:0] pal_mem [PAL_DEPTH];
    logic [63:0] ar_plane [4];
    int          tile_col;
    int          tile_row;
    int          word_idx;
    exp_texel_t  texels_due[$];
    exp_texel_t  word_texels[$];

    assign pending = texels_due.size();

    function automatic int clamp_dim(input logic [10:0] d);
        if (d == 0)
            return 1;
        if (d > MAX_DIM)
            return MAX_DIM;
        return d;
    endfunction

    function automatic color_t c565(input logic [15:0] v);
        color_t c;
        c.r = {v[15:11], v[15:13]};
        c.g = {v[10:5], v[10:9]};
        c.b = {v[4:0], v[4:2]};
        c.a = 8'd255;
        return c;
    endfunction

    function automatic color_t c5a3(input logic [15:0] v);
        color_t c;
        int     a3;
        a3 = v[14:12];
        if (v[15])
        begin
            c.r = {v[14:10], v[14:12]};
            c.g = {v[9:5], v[9:7]};
            c.b = {v[4:0], v[4:2]};
            c.a = 8'd255;
        end
        else
        begin
            c.r = 8'(v[11:8] * 17);
            c.g = 8'(v[7:4] * 17);
            c.b = 8'(v[3:0] * 17);
            c.a = 8'((a3 * 255) / 7);
        end
        return c;
    endfunction

    function automatic color_t cia8(input logic [15:0] v);
        color_t c;
        c.r = v[7:0];
        c.g = v[7:0];
        c.b = v[7:0];
        c.a = v[15:8];
        return c;
    endfunction

    function automatic color_t grey(input int v, input int a);
        color_t c;
        c.r = 8'(v);
        c.g = 8'(v);
        c.b = 8'(v);
        c.a = 8'(a);
        return c;
    endfunction

    function automatic color_t lookup(input int idx);
        logic [15:0] v;
        v = pal_mem[idx % PAL_DEPTH];
        if (cfg_pf == PF_IA8)
            return cia8(v);
        else if (cfg_pf == PF_RGB565)
            return c565(v);
        return c5a3(v);
    endfunction

    function automatic logic [7:0] byte_at(input logic [63:0] w, input int n);
        return w[8*(7-n) +: 8];
    endfunction

    function automatic logic [15:0] half_at(input logic [63:0] w, input int n);
        return w[16*(3-n) +: 16];
    endfunction

    // drops texels outside the image
    task automatic emit(input int x, input int y, input color_t c);
        exp_texel_t t;
        if (x >= clamp_dim(cfg_w) || y >= clamp_dim(cfg_h))
            return;
        t.x = 10'(x);
        t.y = 10'(y);
        t.r = c.r;
        t.g = c.g;
        t.b = c.b;
        t.a = c.a;
        t.last = 1'b0;
        word_texels = {word_texels, t};
    endtask

    task automatic decode_word(input logic [63:0] w);
        int     tw, th, nw, k, x0, y0, i, v, cols, rows;
        int     p [4][4];
        int     sx, sy, bits, sel;
        color_t c, c0, c1;
        exp_texel_t t;
        case (cfg_fmt)
            FMT_I4, FMT_C4, FMT_CMPR:
            begin
                tw = 8;
                th = 8;
            end
            FMT_I8, FMT_IA4, FMT_C8:
            begin
                tw = 8;
                th = 4;
            end
            FMT_IA8, FMT_RGB565, FMT_RGB5A3, FMT_RGBA8, FMT_C14X2:
            begin
                tw = 4;
                th = 4;
            end
            default:
            begin
                tw = 0;
                th = 0;
            end
        endcase
        if (tw == 0)
            return;
        nw = (cfg_fmt == FMT_RGBA8) ? 8 : 4;
        k = (word_idx >= nw) ? 0 : word_idx;
        x0 = tile_col * tw;
        y0 = tile_row * th;
        word_texels.delete();
        case (cfg_fmt)
            FMT_I4, FMT_C4:
                for (int j = 0; j < 16; j++)
                begin
                    v = byte_at(w, j >> 1);
                    v = (j & 1) ? (v & 15) : (v >> 4);
                    i = 16 * k + j;
                    c = (cfg_fmt == FMT_I4) ? grey(v * 17, v * 17) : lookup(v);
                    emit(x0 + (i & 7), y0 + (i >> 3), c);
                end
            FMT_I8, FMT_IA4, FMT_C8:
                for (int j = 0; j < 8; j++)
                begin
                    v = byte_at(w, j);
                    i = 8 * k + j;
                    if (cfg_fmt == FMT_I8)
                        c = grey(v, v);
                    else if (cfg_fmt == FMT_IA4)
                        c = grey((v & 15) * 17, (v >> 4) * 17);
                    else
                        c = lookup(v);
                    emit(x0 + (i & 7), y0 + (i >> 3), c);
                end
            FMT_IA8, FMT_RGB565, FMT_RGB5A3, FMT_C14X2:
                for (int j = 0; j < 4; j++)
                begin
                    v = half_at(w, j);
                    i = 4 * k + j;
                    if (cfg_fmt == FMT_IA8)
                        c = cia8(16'(v));
                    else if (cfg_fmt == FMT_RGB565)
                        c = c565(16'(v));
                    else if (cfg_fmt == FMT_RGB5A3)
                        c = c5a3(16'(v));
                    else
                        c = lookup(v & 16'h3FFF);
                    emit(x0 + (i & 3), y0 + (i >> 2), c);
                end
            FMT_RGBA8:
                if (k < 4)
                    ar_plane[k] = w;
                else
                    for (int j = 0; j < 4; j++)
                    begin
                        i = 4 * (k - 4) + j;
                        c.a = byte_at(ar_plane[k-4], 2 * j);
                        c.r = byte_at(ar_plane[k-4], 2 * j + 1);
                        c.g = byte_at(w, 2 * j);
                        c.b = byte_at(w, 2 * j + 1);
                        emit(x0 + (i & 3), y0 + (i >> 2), c);
                    end
            default:
            begin
                // dxt1 sub-block
                c0 = c565(half_at(w, 0));
                c1 = c565(half_at(w, 1));
                p[0] = '{c0.r, c0.g, c0.b, 255};
                p[1] = '{c1.r, c1.g, c1.b, 255};
                for (int m = 0; m < 3; m++)
                begin
                    if (half_at(w, 0) > half_at(w, 1))
                    begin
                        p[2][m] = (2 * p[0][m] + p[1][m]) / 3;
                        p[3][m] = (p[0][m] + 2 * p[1][m]) / 3;
                    end
                    else
                    begin
                        p[2][m] = (p[0][m] + p[1][m]) / 2;
                        p[3][m] = 0;
                    end
                end
                p[2][3] = 255;
                p[3][3] = (half_at(w, 0) > half_at(w, 1)) ? 255 : 0;
                sx = x0 + (k & 1) * 4;
                sy = y0 + ((k >> 1) & 1) * 4;
                for (int r = 0; r < 4; r++)
                begin
                    bits = byte_at(w, 4 + r);
                    for (int q = 0; q < 4; q++)
                    begin
                        sel = (bits >> (6 - 2 * q)) & 3;
                        c.r = 8'(p[sel][0]);
                        c.g = 8'(p[sel][1]);
                        c.b = 8'(p[sel][2]);
                        c.a = 8'(p[sel][3]);
                        emit(sx + q, sy + r, c);
                    end
                end
            end
        endcase
        // advance the tile position
        cols = (clamp_dim(cfg_w) + tw - 1) / tw;
        rows = (clamp_dim(cfg_h) + th - 1) / th;
        k++;
        if (k >= nw)
        begin
            k = 0;
            tile_col++;
            if (tile_col >= cols)
            begin
                tile_col = 0;
                tile_row++;
                if (tile_row >= rows)
                    tile_row = 0;
            end
        end
        word_idx = k;
        if (word_texels.size() > 0)
        begin
            t = word_texels.pop_back();
            t.last = 1'b1;
            word_texels = {word_texels, t};
        end
        texels_due = {texels_due, word_texels};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        exp_texel_t want, got;
        if (!rst_n)
        begin
            cfg_fmt <= FMT_I4;
            cfg_pf <= PF_IA8;
            cfg_w <= 11'd1;
            cfg_h <= 11'd1;
            tile_col = 0;
            tile_row = 0;
            word_idx = 0;
            texels_due.delete();
            errors = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_FORMAT: cfg_fmt <= pwdata[3:0];
                    REG_PALFMT: cfg_pf <= pwdata[1:0];
                    REG_WIDTH:  cfg_w <= pwdata[10:0];
                    default:    cfg_h <= pwdata[10:0];
                endcase
                tile_col = 0;
                tile_row = 0;
                word_idx = 0;
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser)
                    pal_mem[s_tdata[77:64]] = s_tdata[93:78];
                else
                    decode_word(s_tdata[63:0]);
            end
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[9:0], m_tdata[19:10], m_tdata[27:20], m_tdata[35:28],
                       m_tdata[43:36], m_tdata[51:44], m_tlast};
                if (texels_due.size() == 0)
                begin
                    $display("%0t: texel with none expected, actual %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = texels_due.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.r !== want.r ||
                        got.g !== want.g || got.b !== want.b || got.a !== want.a ||
                        got.last !== want.last)
                    begin
                        $display("%0t: texel mismatch, expected x%0d y%0d rgba %h%h%h%h last %b,",
                            $time, want.x, want.y, want.r, want.g, want.b, want.a, want.last);
                        $display("    actual x%0d y%0d rgba %h%h%h%h last %b",
                            got.x, got.y, got.r, got.g, got.b, got.a, got.last);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

// ----- dv/tb_top.sv -----
// testbench top of the tiled texture decoder: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_top;
    import ttd_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PAL_FILL = 32;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;    // tile_word, palette_index, palette_value, zero pad
    logic        s_tuser = 1'b0;  // func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;         // texel_x, texel_y, red, green, blue, alpha, zero pad
    logic        m_tlast;

    int errors;
    int pending;
    int cycles = 0;
    int send_idle_pct = 31;
    int recv_idle_pct = 68;

    // palette entries written so far; reads must only hit these
    bit written [PAL_DEPTH];
    int written_list[$];

    always #5 clk = ~clk;

    tiled_texture_decoder dut (.*);

    ttd_scoreboard checker_i (.*);

    // receiver stalls at random
    always @(posedge clk)
        if (rst_n)
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // one word on the input channel, with a random gap in front
    task automatic send_word(input bit func, input logic [63:0] tile,
                             input logic [13:0] pidx, input logic [15:0] pval);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {2'b00, pval, pidx, tile};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic write_palette(input logic [13:0] idx, input logic [15:0] val);
        if (!written[idx])
        begin
            written[idx] = 1'b1;
            written_list = {written_list, int'(idx)};
        end
        send_word(1'b1, {$urandom, $urandom}, idx, val);
    endtask

    // drain every expected texel, then let the lane buffer settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // setup and access cycle; the write lands when pready is seen in access
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [10:0] pick_size();
        case ($urandom_range(0, 7))
            0:       return 11'd1;
            1:       return MAX_DIM;
            2:       return 11'd0;       // clamps to one
            3:       return 11'd2047;    // clamps to the maximum
            4:       return 11'($urandom_range(1, 1024));
            default: return 11'($urandom_range(1, 24));
        endcase
    endfunction

    // tile word for the current format; mostly random, sometimes flat extremes
    function automatic logic [63:0] make_tile(input logic [3:0] fmt);
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: w = '0;
            1: w = '1;
            default: ;
        endcase
        // color-index bytes stay inside the filled low palette range
        if (fmt == FMT_C8)
            for (int j = 0; j < 8; j++)
                w[8*j +: 8] = 8'($urandom_range(0, PAL_FILL - 1));
        // color-index halves only point at written palette entries
        if (fmt == FMT_C14X2)
            for (int j = 0; j < 4; j++)
                w[16*j +: 16] = {2'($urandom_range(0, 3)),
                    14'(written_list[$urandom_range(0, written_list.size() - 1)])};
        return w;
    endfunction

    initial
    begin
        logic [3:0]  fmt;
        logic [1:0]  pf;
        logic [10:0] w_size, h_size;
        int          n_words;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: I4, 1x1 image, a single visible texel per tile
        send_word(1'b0, 64'hF0F0_F0F0_F0F0_F0F0, '0, '0);
        send_word(1'b0, '1, '0, '0);
        send_word(1'b0, '0, '0, '0);

        // fill the low palette range used by C4 and C8, then a few high entries
        for (int i = 0; i < PAL_FILL; i++)
            write_palette(14'(i), 16'($urandom));
        write_palette(14'h3FFF, 16'hFFFF);
        write_palette(14'h2000, 16'h0000);
        write_palette(14'h1555, 16'h8000);
        write_palette(14'h2AAA, 16'h7FFF);
        for (int i = 0; i < 4; i++)
            write_palette(14'($urandom_range(256, 16383)), 16'($urandom));

        // sixteen phases walk every format code, then random ones
        for (int ph = 0; ph < 22; ph++)
        begin
            if (ph == 7)
            begin
                send_idle_pct = 68;
                recv_idle_pct = 31;
            end
            if (ph == 15)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            fmt = (ph < 16) ? 4'(ph) : 4'($urandom_range(0, 15));
            pf = (ph < 16) ? 2'(ph) : 2'($urandom_range(0, 3));
            w_size = (ph == 0) ? MAX_DIM : (ph == 1) ? 11'd8 : pick_size();
            h_size = (ph == 0) ? MAX_DIM : (ph == 1) ? 11'd8 : pick_size();

            wait_idle();
            reg_write(REG_PALFMT, 32'(pf));
            reg_write(REG_WIDTH, 32'(w_size));
            reg_write(REG_HEIGHT, 32'(h_size));
            reg_write(REG_FORMAT, 32'(fmt));

            n_words = $urandom_range(5, 10);
            if (fmt == FMT_RGBA8)
                n_words = 16;
            for (int i = 0; i < n_words; i++)
            begin
                // occasional palette rewrites between tile words
                if ($urandom_range(0, 99) < 8)
                    write_palette(14'($urandom), 16'($urandom));
                send_word(1'b0, make_tile(fmt), 14'($urandom), 16'($urandom));
            end
        end

        wait_idle();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/ttd_pkg.sv
rtl/ttd_ram.sv
rtl/ttd_lane.sv
rtl/ttd_cmpr.sv
rtl/tiled_texture_decoder.sv
rtl/ttd_checker.sv
dv/ttd_checker.sv
dv/tb_top.sv
